// ===== src/hltc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the heater level and timer control core.
// Holds key codes, level codes, register indexes and stream word widths.
// No dependencies; used by the core and its checker.
package hltc_pkg;

  // Decoded key commands (codes six and seven are ignored)
  localparam logic [2:0] KEY_NONE   = 3'd0;
  localparam logic [2:0] KEY_SWITCH = 3'd1;
  localparam logic [2:0] KEY_ON     = 3'd2;
  localparam logic [2:0] KEY_OFF    = 3'd3;
  localparam logic [2:0] KEY_LOW    = 3'd4;
  localparam logic [2:0] KEY_MID    = 3'd5;

  // Heater levels
  localparam logic [1:0] LVL_OFF = 2'd0;
  localparam logic [1:0] LVL_LOW = 2'd1;
  localparam logic [1:0] LVL_MAX = 2'd2;

  // Item kinds carried on in_tuser
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_TPM      = 3'd1;
  localparam logic [2:0] REG_DUTY_OFF = 3'd2;
  localparam logic [2:0] REG_DUTY_LOW = 3'd3;
  localparam logic [2:0] REG_DUTY_MAX = 3'd4;

  // Register reset values
  localparam logic [15:0] TPM_RESET = 16'd6000;

  // Stream word widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Maximum number of level sends in one key step
  localparam logic [1:0] SENDS_MAX = 2'd2;

endpackage

// ===== src/heater_level_timer_control_core.sv =====
`timescale 1ns / 1ps
// Top level of the heater level and timer control core.
// Depends on hltc_pkg for key, level and register codes.

// Takes one word per cycle while in_tready is high and returns one result word
// for each. The word is captured in an input register, and the level, timers,
// pending-send flags and duty are updated in one pass as it moves into the
// result register, which happens whenever the result slot is free or being
// taken. The state update is combinational, which sets the rate of one word
// per clock while the output is not stalled. in_tready drops only while both
// the input and result registers hold words and the result is not being
// taken.
// cfg_ready is always high; write the registers only while no word is in
// flight.
module heater_level_timer_control_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hltc_pkg::IN_DATA_W-1:0] in_tdata,  // [2:0] key_cmd, [3] link_ready
  input  logic                           in_tuser,  // [0] kind
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] heat_level, [17:2] drive_duty, [19:18] sends_issued,
  // [20] on_pending, [21] off_pending
  output logic [hltc_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_addr,
  input  logic [15:0]                    cfg_data
);

  // configuration registers
  logic [7:0]  timeout_r;
  logic [15:0] tpm_r;
  logic [15:0] duty_off_r;
  logic [15:0] duty_low_r;
  logic [15:0] duty_max_r;

  // input stage
  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [2:0]  s1_key_r;
  logic        s1_ready_r;

  // control state
  logic [1:0]  level_r,     level_nxt;
  logic [2:0]  last_key_r,  last_key_nxt;
  logic [15:0] tick_r,      tick_nxt;
  logic [7:0]  minute_r,    minute_nxt;
  logic        on_flag_r,   on_flag_nxt;
  logic        off_flag_r,  off_flag_nxt;
  logic [15:0] duty_r,      duty_nxt;
  logic [1:0]  sends_nxt;

  // result stage
  logic        out_valid_r;
  logic [1:0]  out_level_r;
  logic [15:0] out_duty_r;
  logic [1:0]  out_sends_r;
  logic        out_on_r;
  logic        out_off_r;

  logic        advance;
  logic        fire;
  logic [16:0] tick_sum;
  logic [8:0]  minute_sum;

  // pipeline moves when the result slot is free or being taken
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= '0;
      tpm_r      <= hltc_pkg::TPM_RESET;
      duty_off_r <= '0;
      duty_low_r <= '0;
      duty_max_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        hltc_pkg::REG_TIMEOUT:  timeout_r  <= cfg_data[7:0];
        hltc_pkg::REG_TPM:      tpm_r      <= cfg_data;
        hltc_pkg::REG_DUTY_OFF: duty_off_r <= cfg_data;
        hltc_pkg::REG_DUTY_LOW: duty_low_r <= cfg_data;
        hltc_pkg::REG_DUTY_MAX: duty_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r  <= in_tuser;
      s1_key_r   <= in_tdata[2:0];
      s1_ready_r <= in_tdata[3];
    end
  end

  // one pass over the state for the word in the input stage
  always_comb begin
    level_nxt    = level_r;
    last_key_nxt = last_key_r;
    tick_nxt     = tick_r;
    minute_nxt   = minute_r;
    on_flag_nxt  = on_flag_r;
    off_flag_nxt = off_flag_r;
    duty_nxt     = duty_r;
    sends_nxt    = 2'd0;
    tick_sum     = {1'b0, tick_r} + 17'd1;
    minute_sum   = {1'b0, minute_r} + 9'd1;

    if (s1_kind_r == hltc_pkg::KIND_TICK) begin
      // pick duty by level; an undefined level holds it
      unique case (level_r)
        hltc_pkg::LVL_OFF: duty_nxt = duty_off_r;
        hltc_pkg::LVL_LOW: duty_nxt = duty_low_r;
        hltc_pkg::LVL_MAX: duty_nxt = duty_max_r;
        default:           duty_nxt = duty_r;
      endcase
      // count ticks into minutes, saturating at the timeout
      if (level_r != hltc_pkg::LVL_OFF) begin
        if (timeout_r != 8'd0) begin
          if (tick_sum >= {1'b0, tpm_r}) begin
            tick_nxt = '0;
            if (minute_sum >= {1'b0, timeout_r}) begin
              minute_nxt = timeout_r;
            end else begin
              minute_nxt = minute_sum[7:0];
            end
          end else begin
            tick_nxt = tick_sum[15:0];
          end
        end else begin
          minute_nxt = '0;
        end
      end else begin
        tick_nxt   = '0;
        minute_nxt = '0;
      end
    end else if (s1_key_r <= hltc_pkg::KEY_MID) begin
      last_key_nxt = s1_key_r;
      // act on a new command only
      if (s1_key_r != hltc_pkg::KEY_NONE && s1_key_r != last_key_r) begin
        unique case (s1_key_r)
          hltc_pkg::KEY_SWITCH: begin
            if (level_r != hltc_pkg::LVL_OFF) begin
              level_nxt    = hltc_pkg::LVL_OFF;
              off_flag_nxt = 1'b1;
            end else begin
              level_nxt   = hltc_pkg::LVL_MAX;
              on_flag_nxt = 1'b1;
            end
          end
          hltc_pkg::KEY_ON: begin
            level_nxt   = hltc_pkg::LVL_MAX;
            on_flag_nxt = 1'b1;
          end
          hltc_pkg::KEY_OFF: begin
            level_nxt    = hltc_pkg::LVL_OFF;
            off_flag_nxt = 1'b1;
          end
          hltc_pkg::KEY_LOW: begin
            level_nxt    = hltc_pkg::LVL_LOW;
            off_flag_nxt = 1'b1;
          end
          default: begin
            level_nxt    = hltc_pkg::LVL_MAX;
            off_flag_nxt = 1'b1;
          end
        endcase
        tick_nxt   = '0;
        minute_nxt = '0;
      end
      // automatic switch-off on a key word once the timeout is reached
      if (timeout_r != 8'd0 && minute_nxt >= timeout_r) begin
        level_nxt    = hltc_pkg::LVL_OFF;
        tick_nxt     = '0;
        minute_nxt   = '0;
        off_flag_nxt = 1'b1;
      end
      // issue pending sends; link acceptance clears them
      sends_nxt = {1'b0, on_flag_nxt} + {1'b0, off_flag_nxt};
      if (s1_ready_r) begin
        on_flag_nxt  = 1'b0;
        off_flag_nxt = 1'b0;
      end
    end
  end

  // commit state as the word leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= hltc_pkg::LVL_OFF;
      last_key_r <= hltc_pkg::KEY_NONE;
      tick_r     <= '0;
      minute_r   <= '0;
      on_flag_r  <= 1'b0;
      off_flag_r <= 1'b0;
      duty_r     <= '0;
    end else if (fire) begin
      level_r    <= level_nxt;
      last_key_r <= last_key_nxt;
      tick_r     <= tick_nxt;
      minute_r   <= minute_nxt;
      on_flag_r  <= on_flag_nxt;
      off_flag_r <= off_flag_nxt;
      duty_r     <= duty_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_level_r <= level_nxt;
      out_duty_r  <= duty_nxt;
      out_sends_r <= sends_nxt;
      out_on_r    <= on_flag_nxt;
      out_off_r   <= off_flag_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_off_r, out_on_r, out_sends_r, out_duty_r, out_level_r};

endmodule

// ===== src/hltc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the heater level and timer control core.
// Depends on hltc_pkg; bound to heater_level_timer_control_core below.
module hltc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hltc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // level and send count stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 &&
                   out_tdata[19:18] <= hltc_pkg::SENDS_MAX)
    else $error("level or send count out of range");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an empty result slot never back-pressures the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result slot empty");

endmodule

bind heater_level_timer_control_core hltc_checker u_hltc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
